[rtl/csaw_pkg.sv]
// Shared types and constants for the catch-up sender ack window block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package csaw_pkg;

    // Event codes as they arrive on the input mode field.
    localparam logic [2:0] MODE_PREPARE    = 3'd0;
    localparam logic [2:0] MODE_CONFIRM    = 3'd1;
    localparam logic [2:0] MODE_ACK        = 3'd2;
    localparam logic [2:0] MODE_SEND_CHECK = 3'd3;
    localparam logic [2:0] MODE_TICK       = 3'd4;
    localparam logic [2:0] MODE_DONE       = 3'd5;

    // Result status codes.
    localparam logic [2:0] ST_REJECT  = 3'd0;
    localparam logic [2:0] ST_ACCEPT  = 3'd1;
    localparam logic [2:0] ST_GO      = 3'd2;
    localparam logic [2:0] ST_WAIT    = 3'd3;
    localparam logic [2:0] ST_CAUGHT  = 3'd4;
    localparam logic [2:0] ST_TIMEOUT = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] REG_ACK_LEAD_LIMIT     = 2'd0;
    localparam logic [1:0] REG_RECEIVER_LEAD_STEP = 2'd1;
    localparam logic [1:0] REG_PREPARE_TIMEOUT_MS = 2'd2;
    localparam logic [1:0] REG_ACK_TIMEOUT_MS     = 2'd3;

    localparam int CNT_W  = 20;
    localparam int LEAD_W = 16;
    localparam int INST_W = 64;
    localparam int NODE_W = 48;

    localparam logic [CNT_W-1:0]  CNT_MAX = {CNT_W{1'b1}};

    // Reset values of the configuration registers.
    localparam logic [LEAD_W-1:0] RST_ACK_LEAD_LIMIT     = 16'd64;
    localparam logic [LEAD_W-1:0] RST_RECEIVER_LEAD_STEP = 16'd10;
    localparam logic [CNT_W-1:0]  RST_PREPARE_TIMEOUT_MS = 20'd5000;
    localparam logic [CNT_W-1:0]  RST_ACK_TIMEOUT_MS     = 20'd5000;

    // Classified event kind, as the front end hands it to the back end.
    typedef enum logic [2:0] {
        EV_PREPARE,
        EV_CONFIRM,
        EV_ACK,
        EV_SEND_CHECK,
        EV_TICK,
        EV_DONE,
        EV_IGNORE
    } csaw_event_t;

    // One classified transaction travelling through the queue.
    typedef struct packed {
        csaw_event_t        ev;
        logic [INST_W-1:0]  inst;
        logic [NODE_W-1:0]  node;
        logic               completed;
    } csaw_item_t;

endpackage

`default_nettype wire

[rtl/csaw_front.sv]
// Front end: accepts input transactions, classifies the mode and registers them.
// Depends on csaw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csaw_front
    import csaw_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_mode,
    input  wire logic [INST_W-1:0]  s_instance_id,
    input  wire logic [NODE_W-1:0]  s_node_id,
    input  wire logic               s_completed,
    output logic                    q_valid,
    input  wire logic               q_ready,
    output csaw_item_t              q_item
);

    logic       valid_reg;
    csaw_item_t item_reg;
    csaw_item_t item_next;

    // Map the raw mode to an event kind; unused codes are ignored downstream.
    always_comb begin
        item_next.inst      = s_instance_id;
        item_next.node      = s_node_id;
        item_next.completed = s_completed;
        case (s_mode)
            MODE_PREPARE:    item_next.ev = EV_PREPARE;
            MODE_CONFIRM:    item_next.ev = EV_CONFIRM;
            MODE_ACK:        item_next.ev = EV_ACK;
            MODE_SEND_CHECK: item_next.ev = EV_SEND_CHECK;
            MODE_TICK:       item_next.ev = EV_TICK;
            MODE_DONE:       item_next.ev = EV_DONE;
            default:         item_next.ev = EV_IGNORE;
        endcase
    end

    // The stage takes a new transaction whenever it is empty or drains this cycle.
    assign s_ready = !valid_reg || q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            item_reg <= item_next;
        end
    end

    assign q_valid = valid_reg;
    assign q_item  = item_reg;

endmodule

`default_nettype wire

[rtl/csaw_queue.sv]
// Two-entry queue that decouples the front end from the back end.
// Depends on csaw_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none

module csaw_queue
    import csaw_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  csaw_item_t  in_item,
    output logic        out_valid,
    input  wire logic   out_ready,
    output csaw_item_t  out_item
);

    csaw_item_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Occupancy moves only when exactly one side transfers.
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

[rtl/csaw_back.sv]
// Back end: holds the session state and configuration, executes events
// and registers one result per transaction. Depends on csaw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csaw_back
    import csaw_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [CNT_W-1:0]   cfg_wdata,
    input  wire logic               q_valid,
    output logic                    q_ready,
    input  csaw_item_t              q_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [2:0]              m_status,
    output logic                    m_session_confirmed,
    output logic [INST_W-1:0]       m_acked_instance
);

    // Configuration registers.
    logic [LEAD_W-1:0] ack_lead_limit_reg;
    logic [LEAD_W-1:0] receiver_lead_step_reg;
    logic [CNT_W-1:0]  prepare_timeout_ms_reg;
    logic [CNT_W-1:0]  ack_timeout_ms_reg;

    // Session state.
    logic              sending_reg,      sending_next;
    logic              confirmed_reg,    confirmed_next;
    logic [INST_W-1:0] begin_inst_reg,   begin_inst_next;
    logic [NODE_W-1:0] peer_node_reg,    peer_node_next;
    logic [INST_W-1:0] ack_inst_reg,     ack_inst_next;
    logic [CNT_W-1:0]  since_send_reg,   since_send_next;
    logic [CNT_W-1:0]  since_ack_reg,    since_ack_next;
    logic [LEAD_W-1:0] lead_reg,         lead_next;

    // Result register.
    logic              m_valid_reg;
    logic [2:0]        status_reg,       status_next;

    logic              take;
    logic              active;
    logic              behind;
    logic              over_lead;
    logic              lead_above_floor;
    logic [INST_W:0]   window_end;

    // The result register frees up when it is empty or being taken.
    assign q_ready = !m_valid_reg || m_ready;
    assign take    = q_valid && q_ready;

    // Shared conditions of the current session.
    assign active           = sending_reg && (since_send_reg < prepare_timeout_ms_reg);
    assign behind           = q_item.inst < ack_inst_reg;
    assign window_end       = {1'b0, ack_inst_reg} + {{(INST_W+1-LEAD_W){1'b0}}, lead_reg};
    assign over_lead        = {1'b0, q_item.inst} > window_end;
    assign lead_above_floor = {1'b0, lead_reg} > {receiver_lead_step_reg, 1'b0};

    // Event execution.
    always_comb begin
        sending_next    = sending_reg;
        confirmed_next  = confirmed_reg;
        begin_inst_next = begin_inst_reg;
        peer_node_next  = peer_node_reg;
        ack_inst_next   = ack_inst_reg;
        since_send_next = since_send_reg;
        since_ack_next  = since_ack_reg;
        lead_next       = lead_reg;
        status_next     = ST_REJECT;
        case (q_item.ev)
            EV_PREPARE: begin
                if (!active && !confirmed_reg) begin
                    sending_next    = 1'b1;
                    since_send_next = '0;
                    since_ack_next  = '0;
                    begin_inst_next = q_item.inst;
                    ack_inst_next   = q_item.inst;
                    peer_node_next  = q_item.node;
                    status_next     = ST_ACCEPT;
                end
            end
            EV_CONFIRM: begin
                if (active && !confirmed_reg && (begin_inst_reg == q_item.inst)
                        && (peer_node_reg == q_item.node)) begin
                    confirmed_next = 1'b1;
                    status_next    = ST_ACCEPT;
                end
            end
            EV_ACK: begin
                if (active && confirmed_reg && (peer_node_reg == q_item.node)
                        && (q_item.inst > ack_inst_reg)) begin
                    ack_inst_next  = q_item.inst;
                    since_ack_next = '0;
                    status_next    = ST_ACCEPT;
                end
            end
            EV_SEND_CHECK: begin
                if (behind) begin
                    lead_next   = ack_lead_limit_reg;
                    status_next = ST_CAUGHT;
                end else if (over_lead) begin
                    if (since_ack_reg >= ack_timeout_ms_reg) begin
                        if (lead_above_floor) begin
                            lead_next = lead_reg - receiver_lead_step_reg;
                        end
                        status_next = ST_TIMEOUT;
                    end else begin
                        status_next = ST_WAIT;
                    end
                end else begin
                    since_send_next = '0;
                    status_next     = ST_GO;
                end
            end
            EV_TICK: begin
                if (since_send_reg != CNT_MAX) begin
                    since_send_next = since_send_reg + 1'b1;
                end
                if (since_ack_reg != CNT_MAX) begin
                    since_ack_next = since_ack_reg + 1'b1;
                end
                status_next = ST_ACCEPT;
            end
            EV_DONE: begin
                if (q_item.completed) begin
                    lead_next = ack_lead_limit_reg;
                end
                sending_next    = 1'b0;
                confirmed_next  = 1'b0;
                begin_inst_next = '1;
                peer_node_next  = '0;
                ack_inst_next   = '0;
                since_send_next = '0;
                since_ack_next  = '0;
                status_next     = ST_ACCEPT;
            end
            default: begin
                status_next = ST_REJECT;
            end
        endcase
    end

    // State, configuration and result registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ack_lead_limit_reg     <= RST_ACK_LEAD_LIMIT;
            receiver_lead_step_reg <= RST_RECEIVER_LEAD_STEP;
            prepare_timeout_ms_reg <= RST_PREPARE_TIMEOUT_MS;
            ack_timeout_ms_reg     <= RST_ACK_TIMEOUT_MS;
            sending_reg            <= 1'b0;
            confirmed_reg          <= 1'b0;
            begin_inst_reg         <= '1;
            peer_node_reg          <= '0;
            ack_inst_reg           <= '0;
            since_send_reg         <= '0;
            since_ack_reg          <= '0;
            lead_reg               <= RST_ACK_LEAD_LIMIT;
            m_valid_reg            <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_ACK_LEAD_LIMIT:     ack_lead_limit_reg     <= cfg_wdata[LEAD_W-1:0];
                    REG_RECEIVER_LEAD_STEP: receiver_lead_step_reg <= cfg_wdata[LEAD_W-1:0];
                    REG_PREPARE_TIMEOUT_MS: prepare_timeout_ms_reg <= cfg_wdata;
                    REG_ACK_TIMEOUT_MS:     ack_timeout_ms_reg     <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (take) begin
                sending_reg    <= sending_next;
                confirmed_reg  <= confirmed_next;
                begin_inst_reg <= begin_inst_next;
                peer_node_reg  <= peer_node_next;
                ack_inst_reg   <= ack_inst_next;
                since_send_reg <= since_send_next;
                since_ack_reg  <= since_ack_next;
                lead_reg       <= lead_next;
            end
            if (q_ready) begin
                m_valid_reg <= q_valid;
            end
        end
        if (take) begin
            status_reg <= status_next;
        end
    end

    // The flags in the result are the registered state after the event.
    assign m_valid             = m_valid_reg;
    assign m_status            = status_reg;
    assign m_session_confirmed = confirmed_reg;
    assign m_acked_instance    = ack_inst_reg;

endmodule

`default_nettype wire

[rtl/catchup_sender_ack_window.sv]
// Catch-up sender session controller, top level.
// A result is registered after its transaction passes the front stage, the queue and
// the back end. Throughput: one transaction per cycle while m_ready is held high;
// the back end updates all session state as it takes an event, so events follow each other without gaps.
// Reset (aresetn, synchronous, active low) clears the session, loads the
// register defaults and empties the front stage, queue and result register.
`timescale 1ns / 1ps
`default_nettype none

module catchup_sender_ack_window
    import csaw_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [CNT_W-1:0]   cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_mode,
    input  wire logic [INST_W-1:0]  s_instance_id,
    input  wire logic [NODE_W-1:0]  s_node_id,
    input  wire logic               s_completed,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [2:0]              m_status,
    output logic                    m_session_confirmed,
    output logic [INST_W-1:0]       m_acked_instance
);

    logic       front_valid;
    logic       front_ready;
    csaw_item_t front_item;
    logic       back_valid;
    logic       back_ready;
    csaw_item_t back_item;

    csaw_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_instance_id (s_instance_id),
        .s_node_id     (s_node_id),
        .s_completed   (s_completed),
        .q_valid       (front_valid),
        .q_ready       (front_ready),
        .q_item        (front_item)
    );

    csaw_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_item  (back_item)
    );

    csaw_back u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .q_valid             (back_valid),
        .q_ready             (back_ready),
        .q_item              (back_item),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_session_confirmed (m_session_confirmed),
        .m_acked_instance    (m_acked_instance)
    );

endmodule

`default_nettype wire
